// ===== rtl/sac_pkg.sv =====
// Shared types and constants for the archive symbol-map stream checker.
package sac_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SHORT  = 2'd1;
  localparam logic [1:0] ST_BADTAB = 2'd2;

  localparam logic KIND_OFFSET = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] LANE_LAST = 2'd3;

  typedef enum logic [2:0] {
    PH_COUNT = 3'b001,
    PH_REFS  = 3'b010,
    PH_TABLE = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] symbol_index;
    logic [31:0] member_offset;
    logic [1:0]  status;
    logic        run_end;
  } result_t;

  typedef struct packed {
    logic        has_offset;
    logic [31:0] symbol_index;
    logic [31:0] member_offset;
    logic        has_status;
    logic [1:0]  status;
  } entry_t;

endpackage

// ===== rtl/sac_front.sv =====
// Byte parser: decodes count and offsets, checks the string table, emits work entries.
module sac_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  sac_pkg::item_t  item,
  output logic            entry_valid,
  output sac_pkg::entry_t entry
);

  sac_pkg::phase_t phase, phase_next;
  logic [31:0] symbol_count, symbol_count_next;
  logic [1:0]  byte_lane, byte_lane_next;
  logic [23:0] word_accum, word_accum_next;
  logic [31:0] ref_index, ref_index_next;
  logic [31:0] strings_seen, strings_seen_next;
  logic        prev_was_zero, prev_was_zero_next;
  logic        table_started, table_started_next;
  logic        table_bad, table_bad_next;

  logic        is_zero;
  logic [31:0] word;

  always_comb begin
    phase_next         = phase;
    symbol_count_next  = symbol_count;
    byte_lane_next     = byte_lane;
    word_accum_next    = word_accum;
    ref_index_next     = ref_index;
    strings_seen_next  = strings_seen;
    prev_was_zero_next = prev_was_zero;
    table_started_next = table_started;
    table_bad_next     = table_bad;
    entry              = '0;
    is_zero            = (item.data_byte == 8'd0);
    word               = {word_accum, item.data_byte};

    if (accept) begin
      if (phase == sac_pkg::PH_TABLE) begin
        if (!table_started) begin
          table_started_next = 1'b1;
          if (symbol_count != 32'd0 && is_zero) begin
            table_bad_next = 1'b1;
          end
        end else if (is_zero) begin
          if (prev_was_zero) begin
            if (strings_seen < symbol_count) begin
              table_bad_next = 1'b1;
            end
          end else if (strings_seen == symbol_count) begin
            table_bad_next = 1'b1;
          end else begin
            strings_seen_next = strings_seen + 32'd1;
          end
        end
        prev_was_zero_next = is_zero;
      end else if (byte_lane != sac_pkg::LANE_LAST) begin
        word_accum_next = {word_accum[15:0], item.data_byte};
        byte_lane_next  = byte_lane + 2'd1;
      end else begin
        word_accum_next = '0;
        byte_lane_next  = '0;
        if (phase == sac_pkg::PH_COUNT) begin
          symbol_count_next = word;
          phase_next = (word == 32'd0) ? sac_pkg::PH_TABLE : sac_pkg::PH_REFS;
        end else begin
          entry.has_offset    = 1'b1;
          entry.symbol_index  = ref_index;
          entry.member_offset = word;
          ref_index_next      = ref_index + 32'd1;
          if (ref_index_next == symbol_count) begin
            phase_next = sac_pkg::PH_TABLE;
          end
        end
      end

      if (item.final_byte) begin
        entry.has_status = 1'b1;
        if (phase_next != sac_pkg::PH_TABLE) begin
          entry.status = sac_pkg::ST_SHORT;
        end else if (!table_started_next) begin
          entry.status = (symbol_count_next != 32'd0) ? sac_pkg::ST_BADTAB : sac_pkg::ST_OK;
        end else if (table_bad_next) begin
          entry.status = sac_pkg::ST_BADTAB;
        end else if (strings_seen_next != symbol_count_next) begin
          entry.status = sac_pkg::ST_BADTAB;
        end else if (!is_zero) begin
          entry.status = sac_pkg::ST_BADTAB;
        end else begin
          entry.status = sac_pkg::ST_OK;
        end
        phase_next         = sac_pkg::PH_COUNT;
        symbol_count_next  = '0;
        byte_lane_next     = '0;
        word_accum_next    = '0;
        ref_index_next     = '0;
        strings_seen_next  = '0;
        prev_was_zero_next = 1'b0;
        table_started_next = 1'b0;
        table_bad_next     = 1'b0;
      end
    end
  end

  assign entry_valid = entry.has_offset | entry.has_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sac_pkg::PH_COUNT;
      symbol_count  <= '0;
      byte_lane     <= '0;
      word_accum    <= '0;
      ref_index     <= '0;
      strings_seen  <= '0;
      prev_was_zero <= 1'b0;
      table_started <= 1'b0;
      table_bad     <= 1'b0;
    end else begin
      phase         <= phase_next;
      symbol_count  <= symbol_count_next;
      byte_lane     <= byte_lane_next;
      word_accum    <= word_accum_next;
      ref_index     <= ref_index_next;
      strings_seen  <= strings_seen_next;
      prev_was_zero <= prev_was_zero_next;
      table_started <= table_started_next;
      table_bad     <= table_bad_next;
    end
  end

endmodule

// ===== rtl/sac_queue.sv =====
// Short entry queue between the parser and the result stage.
module sac_queue #(
  parameter int unsigned Depth = sac_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  sac_pkg::entry_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output sac_pkg::entry_t rd_data,
  output logic            not_empty
);

  localparam int unsigned AddrWidth  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountWidth = $clog2(Depth + 1);
  localparam logic [AddrWidth-1:0]  LastAddr  = AddrWidth'(Depth - 1);
  localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

  sac_pkg::entry_t       mem [Depth];
  logic [AddrWidth-1:0]  wr_ptr;
  logic [AddrWidth-1:0]  rd_ptr;
  logic [CountWidth-1:0] fill;

  assign full      = (fill == FullCount);
  assign not_empty = (fill != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LastAddr) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LastAddr) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/sac_back.sv =====
// Result stage: expands entries into offset and status beats behind an output register.
module sac_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             entry_valid,
  input  sac_pkg::entry_t  entry,
  output logic             entry_take,
  output logic             empty,
  input  logic             pop,
  output sac_pkg::result_t result
);

  logic             out_valid;
  sac_pkg::result_t out_beat;
  logic             pend_valid;
  logic [1:0]       pend_status;
  logic             slot_free;
  logic             take_pend;

  assign slot_free  = !out_valid || pop;
  assign take_pend  = slot_free && pend_valid;
  assign entry_take = slot_free && !pend_valid && entry_valid;
  assign empty      = !out_valid;
  assign result     = out_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (take_pend) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (entry_take) begin
        out_valid  <= 1'b1;
        pend_valid <= entry.has_offset && entry.has_status;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_pend) begin
      out_beat <= '{kind: sac_pkg::KIND_STATUS, symbol_index: '0, member_offset: '0,
                    status: pend_status, run_end: 1'b1};
    end else if (entry_take) begin
      pend_status <= entry.status;
      if (entry.has_offset) begin
        out_beat <= '{kind: sac_pkg::KIND_OFFSET, symbol_index: entry.symbol_index,
                      member_offset: entry.member_offset, status: sac_pkg::ST_OK,
                      run_end: !entry.has_status};
      end else begin
        out_beat <= '{kind: sac_pkg::KIND_STATUS, symbol_index: '0, member_offset: '0,
                      status: entry.status, run_end: 1'b1};
      end
    end
  end

endmodule

// ===== rtl/sysv_armap_stream_checker.sv =====
// Top level of the SysV archive symbol-map stream checker.
//
//   channel  direction  handshake                  beat
//   item     in         push / full                item_t   (data_byte, final_byte)
//   result   out        pop / empty                result_t (kind, symbol_index, ...)
//
// One byte is taken each cycle while the entry queue has room; the parser
// finishes each byte in the cycle it is accepted. A result passes through the
// entry queue and then the output register before it is on the ports. A final
// byte that completes an offset yields two beats, offset then status, from the
// output register. Reset clears parser state, queue and output register. A stalled
// result side backs up into the queue, then full.
module sysv_armap_stream_checker #(
  parameter int unsigned QueueDepth = sac_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  sac_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output sac_pkg::result_t result
);

  logic            accept;
  logic            wr_en;
  sac_pkg::entry_t wr_data;
  logic            rd_en;
  sac_pkg::entry_t rd_data;
  logic            not_empty;

  assign accept = push && !full;

  sac_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .entry_valid (wr_en),
    .entry       (wr_data)
  );

  sac_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_data   (wr_data),
    .full      (full),
    .rd_en     (rd_en),
    .rd_data   (rd_data),
    .not_empty (not_empty)
  );

  sac_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (not_empty),
    .entry       (rd_data),
    .entry_take  (rd_en),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule
